// File: sv/crm_pkg.sv
package crm_pkg;

    // storage sizes, both powers of two
    localparam int unsigned ROM_DEPTH = 524288;
    localparam int unsigned RAM_DEPTH = 8192;
    localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

    // decoupling queue between decode and memory access
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // mapping modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_LOW  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNMAPPED = 2'd1;
    localparam logic [1:0] STAT_NOCART   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MAP_MODE    = 2'd0;
    localparam logic [1:0] REG_ROM_LOG2    = 2'd1;
    localparam logic [1:0] REG_RAM_LOG2    = 2'd2;
    localparam logic [1:0] REG_RAM_PRESENT = 2'd3;

    typedef enum logic [2:0] {
        ACC_FIXED,
        ACC_RAM_RD,
        ACC_RAM_WR,
        ACC_ROM_RD,
        ACC_ROM_WR
    } t_acc;

    typedef enum logic [1:0] {
        SRC_FIXED,
        SRC_RAM,
        SRC_ROM
    } t_src;

    typedef enum logic {
        BS_CLEAR,
        BS_RUN
    } t_bstate;

    typedef struct packed {
        logic [1:0] map_mode;
        logic [4:0] rom_size_log2;
        logic [4:0] ram_size_log2;
        logic       ram_present;
    } t_cfg;

    typedef struct packed {
        t_acc              kind;
        logic [RAM_AW-1:0] ram_idx;
        logic [ROM_AW-1:0] rom_idx;
        logic [7:0]        data;
        logic [1:0]        status;
    } t_entry;

endpackage

// File: sv/crm_ram.sv
module crm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/crm_front.sv
module crm_front
    import crm_pkg::*;
(
    input  logic       i_in_valid,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_bank,
    input  logic [15:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_open_bus_value,
    input  t_cfg       i_cfg,
    input  logic       i_q_full,
    input  logic       i_busy,
    output logic       o_in_stall,
    output logic       o_push,
    output t_entry     o_entry
);

    logic              mapped;
    logic              low_ram;
    logic              high_ram;
    logic              ram_hit;
    logic              rom_hit;
    logic              load_ok;
    logic [18:0]       ram_full;
    logic [21:0]       rom_full;
    logic [23:0]       load_off;
    logic [RAM_AW-1:0] ram_mask;
    logic [ROM_AW-1:0] rom_mask;
    logic [RAM_AW-1:0] ram_idx;
    logic [ROM_AW-1:0] rom_idx;

    assign o_in_stall = i_q_full | i_busy;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        mapped   = (i_cfg.map_mode == MODE_LOW) || (i_cfg.map_mode == MODE_HIGH);

        // save ram windows
        low_ram  = i_cfg.ram_present && (i_cfg.map_mode == MODE_LOW) && !i_address[15]
                   && (((i_bank >= 8'h70) && (i_bank < 8'h7e)) || (i_bank >= 8'hf0));
        high_ram = i_cfg.ram_present && (i_cfg.map_mode == MODE_HIGH) && !i_bank[6]
                   && (i_address[15:13] == 3'b011);
        ram_hit  = low_ram | high_ram;

        // rom reached unless lower half of banks 00-3f (bit 7 ignored)
        rom_hit  = i_address[15] | i_bank[6];

        ram_full = (i_cfg.map_mode == MODE_LOW) ? {i_bank[3:0], i_address[14:0]}
                                                : {i_bank[5:0], i_address[12:0]};
        rom_full = (i_cfg.map_mode == MODE_LOW) ? {i_bank[6:0], i_address[14:0]}
                                                : {i_bank[5:0], i_address};

        ram_mask = ~({RAM_AW{1'b1}} << i_cfg.ram_size_log2);
        rom_mask = ~({ROM_AW{1'b1}} << i_cfg.rom_size_log2);
        ram_idx  = ram_full[RAM_AW-1:0] & ram_mask;
        rom_idx  = rom_full[ROM_AW-1:0] & rom_mask;

        load_off = {i_bank, i_address};
        load_ok  = (load_off >> ROM_AW) == 24'd0;
    end

    always_comb begin
        o_entry         = '0;
        o_entry.kind    = ACC_FIXED;
        o_entry.ram_idx = ram_idx;
        o_entry.rom_idx = rom_idx;
        o_entry.status  = STAT_OK;
        unique case (i_operation)
            OP_READ: begin
                priority if (!mapped) begin
                    o_entry.data   = i_open_bus_value;
                    o_entry.status = STAT_NOCART;
                end else if (ram_hit) begin
                    o_entry.kind = ACC_RAM_RD;
                end else if (rom_hit) begin
                    o_entry.kind = ACC_ROM_RD;
                end else begin
                    o_entry.data   = i_open_bus_value;
                    o_entry.status = STAT_UNMAPPED;
                end
            end
            OP_WRITE: begin
                priority if (!mapped) begin
                    o_entry.status = STAT_NOCART;
                end else if (ram_hit) begin
                    o_entry.kind = ACC_RAM_WR;
                    o_entry.data = i_write_data;
                end else begin
                    o_entry.status = STAT_UNMAPPED;
                end
            end
            OP_LOAD: begin
                if (load_ok) begin
                    o_entry.kind    = ACC_ROM_WR;
                    o_entry.rom_idx = load_off[ROM_AW-1:0];
                    o_entry.data    = i_write_data;
                end else begin
                    o_entry.status = STAT_UNMAPPED;
                end
            end
            default: begin
                o_entry.status = STAT_UNMAPPED;
            end
        endcase
    end

endmodule

// File: sv/crm_fifo.sv
module crm_fifo
    import crm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_valid,
    output logic   o_full
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic [Q_AW-1:0] n_wr_ptr;
    logic [Q_AW-1:0] n_rd_ptr;
    logic [Q_AW:0]   n_count;

    assign o_entry = r_mem[r_rd_ptr];
    assign o_valid = r_count != '0;
    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// File: sv/crm_back.sv
module crm_back
    import crm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_q_entry,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_read_data,
    output logic [1:0] o_status,
    output logic       o_busy
);

    t_bstate           r_state;
    t_bstate           n_state;
    logic [RAM_AW-1:0] r_clr_addr;
    logic [RAM_AW-1:0] n_clr_addr;

    logic              r_s1_valid;
    t_src              r_s1_src;
    logic [7:0]        r_s1_data;
    logic [1:0]        r_s1_status;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic [1:0]        r_out_status;

    logic              out_load;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic              rom_we;
    logic              rom_re;
    logic [7:0]        ram_rdata;
    logic [7:0]        rom_rdata;
    t_src              n_s1_src;
    logic [7:0]        n_out_data;

    // clearing sequencer, next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            BS_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {RAM_AW{1'b1}}) begin
                    n_state = BS_RUN;
                end
            end
            BS_RUN: begin
                n_state = BS_RUN;
            end
            default: begin
                n_state = BS_CLEAR;
            end
        endcase
    end

    // clearing sequencer, outputs
    always_comb begin
        unique case (r_state)
            BS_CLEAR: o_busy = 1'b1;
            BS_RUN:   o_busy = 1'b0;
            default:  o_busy = 1'b1;
        endcase
    end

    assign out_load = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_pop    = i_q_valid & ~o_busy & (~r_s1_valid | out_load);

    always_comb begin
        ram_we    = o_busy | (o_pop && (i_q_entry.kind == ACC_RAM_WR));
        ram_waddr = o_busy ? r_clr_addr : i_q_entry.ram_idx;
        ram_wdata = o_busy ? 8'd0 : i_q_entry.data;
        ram_re    = o_pop && (i_q_entry.kind == ACC_RAM_RD);
        rom_we    = o_pop && (i_q_entry.kind == ACC_ROM_WR);
        rom_re    = o_pop && (i_q_entry.kind == ACC_ROM_RD);

        unique case (i_q_entry.kind)
            ACC_RAM_RD: n_s1_src = SRC_RAM;
            ACC_ROM_RD: n_s1_src = SRC_ROM;
            default:    n_s1_src = SRC_FIXED;
        endcase

        unique case (r_s1_src)
            SRC_RAM: n_out_data = ram_rdata;
            SRC_ROM: n_out_data = rom_rdata;
            default: n_out_data = r_s1_data;
        endcase
    end

    crm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_save_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_q_entry.ram_idx),
        .o_rdata (ram_rdata)
    );

    crm_ram #(
        .WIDTH (8),
        .DEPTH (ROM_DEPTH)
    ) u_rom_store (
        .i_clk   (i_clk),
        .i_we    (rom_we),
        .i_waddr (i_q_entry.rom_idx),
        .i_wdata (i_q_entry.data),
        .i_re    (rom_re),
        .i_raddr (i_q_entry.rom_idx),
        .o_rdata (rom_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_src    <= n_s1_src;
            r_s1_data   <= (i_q_entry.kind == ACC_FIXED) ? i_q_entry.data : 8'd0;
            r_s1_status <= i_q_entry.status;
        end
        if (out_load) begin
            r_out_data   <= n_out_data;
            r_out_status <= r_s1_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;

endmodule

// File: sv/cartridge_rom_ram_mapper.sv
// cartridge bus decoder: each transfer on the input channel is a bus read, a bus write or a
// rom load byte, and gives exactly one result (read_data, status) in the same order. a
// sustained rate of one item per clock is reached while neither the receiver stalls nor
// the clearing pass runs; a result passes the queue, memory access with registered read
// and output register. after reset the save ram is cleared, one byte a cycle, over all
// RAM_DEPTH entries (8192 here); input stall stays high during that pass while register
// writes are taken. registers sit at byte addresses 0 (map_mode), 4 (rom_size_log2),
// 8 (ram_size_log2) and 12 (ram_present); change them only while the block is idle.
module cartridge_rom_ram_mapper
    import crm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // apb-style register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // item input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_bank,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_open_bus_value,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_status
);

    // configuration registers
    logic [1:0] r_map_mode;
    logic [4:0] r_rom_size_log2;
    logic [4:0] r_ram_size_log2;
    logic       r_ram_present;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    t_cfg       cfg;

    // front to queue to back
    logic       push;
    t_entry     push_entry;
    logic       q_full;
    logic       q_valid;
    t_entry     q_entry;
    logic       pop;
    logic       busy;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode      <= MODE_NONE;
            r_rom_size_log2 <= 5'd19;
            r_ram_size_log2 <= 5'd11;
            r_ram_present   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_MAP_MODE:    r_map_mode      <= pwdata[1:0];
                REG_ROM_LOG2:    r_rom_size_log2 <= pwdata[4:0];
                REG_RAM_LOG2:    r_ram_size_log2 <= pwdata[4:0];
                REG_RAM_PRESENT: r_ram_present   <= pwdata[0];
                default:         r_map_mode      <= r_map_mode;
            endcase
        end
    end

    // register read back, zero extended
    always_comb begin
        unique case (cfg_idx)
            REG_MAP_MODE:    prdata = {30'd0, r_map_mode};
            REG_ROM_LOG2:    prdata = {27'd0, r_rom_size_log2};
            REG_RAM_LOG2:    prdata = {27'd0, r_ram_size_log2};
            REG_RAM_PRESENT: prdata = {31'd0, r_ram_present};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.map_mode      = r_map_mode;
        cfg.rom_size_log2 = r_rom_size_log2;
        cfg.ram_size_log2 = r_ram_size_log2;
        cfg.ram_present   = r_ram_present;
    end

    // decode: window hits, masked indices, fixed answers
    crm_front u_front (
        .i_in_valid       (i_in_valid),
        .i_operation      (i_operation),
        .i_bank           (i_bank),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .i_open_bus_value (i_open_bus_value),
        .i_cfg            (cfg),
        .i_q_full         (q_full),
        .i_busy           (busy),
        .o_in_stall       (o_in_stall),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    // short queue so decode keeps taking items while the output is held
    crm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // memory access, save ram clearing and result register
    crm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_read_data (o_read_data),
        .o_status    (o_status),
        .o_busy      (busy)
    );

    // clearing pass runs once after reset and never comes back
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("save ram clearing restarted");

    // nothing can be queued or delivered before the save ram is clean
    a_idle_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!q_valid && !o_out_valid))
        else $error("item in flight during clearing pass");

    // the back end only draws from the queue once clearing is over
    a_no_pop_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (!busy && q_valid))
        else $error("queue read while clearing or empty");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

// cartridge mapper testbench: directed checks of each mapping window, then random traffic
// under three idling profiles, every result compared against a behavioural model of the
// bank:address decode, the save ram and the loaded rom bytes
module tb;
    import crm_pkg::*;

    // codes that the package leaves unnamed
    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // watchdog limit covers the save ram clear pass and all the traffic
    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int unsigned ITEMS_PER_PHASE   = 430;
    localparam int unsigned ITEMS_PER_SETTING = 130;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  bank;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  open_bus_value;
    } t_bus_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [7:0]  i_bank;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic [7:0]  i_open_bus_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_read_data;
    logic [1:0]  o_status;

    // model state: register copies, save ram image, rom bytes loaded so far
    logic [1:0]  cfg_mode     = MODE_NONE;
    logic [4:0]  cfg_rom_log2 = 5'd19;
    logic [4:0]  cfg_ram_log2 = 5'd11;
    logic        cfg_ram_on   = 1'b1;
    logic [7:0]  sram_image [RAM_DEPTH];
    logic [7:0]  rom_image [int unsigned];
    int unsigned loaded_offsets [$];

    // results owed by the block, oldest first
    t_result     pending_results [$];

    int unsigned in_gap_pct;
    int unsigned out_stall_pct;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    cartridge_rom_ram_mapper u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_bank           (i_bank),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .i_open_bus_value (i_open_bus_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_data      (o_read_data),
        .o_status         (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // decode model
    // ---------------------------------------------------------------------------------

    // size registers above the storage depth act as the depth
    function automatic int unsigned size_mask(logic [4:0] log2, int unsigned aw);
        int unsigned k;
        k = (log2 < aw) ? log2 : aw;
        return (32'd1 << k) - 32'd1;
    endfunction

    // save ram windows: low map banks 70-7d and f0-ff below 8000, high map 6000-7fff
    // of banks 00-3f with bank bit 7 ignored
    function automatic bit sram_window(logic [7:0] bank, logic [15:0] adr,
                                       output int unsigned idx);
        int unsigned bk;
        int unsigned ad;
        int unsigned b;
        bk  = bank;
        ad  = adr;
        b   = bk & 32'h7f;
        idx = 0;
        if (!cfg_ram_on)
            return 1'b0;
        if (cfg_mode == MODE_LOW) begin
            if (((bk >= 32'h70 && bk < 32'h7e) || bk >= 32'hf0) && ad < 32'h8000) begin
                idx = (((bk & 32'hf) << 15) | ad) & size_mask(cfg_ram_log2, RAM_AW);
                return 1'b1;
            end
        end else if (cfg_mode == MODE_HIGH) begin
            if (b < 32'h40 && ad >= 32'h6000 && ad <= 32'h7fff) begin
                idx = (((b & 32'h3f) << 13) | (ad & 32'h1fff))
                      & size_mask(cfg_ram_log2, RAM_AW);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // rom: everything but the lower half of banks 00-3f (bit 7 ignored); 32k pages
    // in low map, 64k pages in high map
    function automatic bit rom_window(logic [7:0] bank, logic [15:0] adr,
                                      output int unsigned idx);
        int unsigned ad;
        int unsigned b;
        ad  = adr;
        b   = bank & 8'h7f;
        idx = 0;
        if (ad < 32'h8000 && b < 32'h40)
            return 1'b0;
        if (cfg_mode == MODE_LOW)
            idx = ((b << 15) | (ad & 32'h7fff)) & size_mask(cfg_rom_log2, ROM_AW);
        else
            idx = (((b & 32'h3f) << 16) | ad) & size_mask(cfg_rom_log2, ROM_AW);
        return 1'b1;
    endfunction

    // works out the result of one transfer and applies its side effects to the model
    function automatic t_result predict_access(t_bus_item it);
        t_result     res;
        int unsigned idx;
        int unsigned off;
        bit          mapped;
        res    = '{read_data: 8'h00, status: STAT_OK};
        mapped = (cfg_mode == MODE_LOW || cfg_mode == MODE_HIGH);
        case (it.op)
            OP_READ: begin
                if (!mapped) begin
                    res.read_data = it.open_bus_value;
                    res.status    = STAT_NOCART;
                end else if (sram_window(it.bank, it.address, idx)) begin
                    res.read_data = sram_image[idx];
                end else if (rom_window(it.bank, it.address, idx)) begin
                    res.read_data = rom_image.exists(idx) ? rom_image[idx] : 8'h00;
                end else begin
                    res.read_data = it.open_bus_value;
                    res.status    = STAT_UNMAPPED;
                end
            end
            OP_WRITE: begin
                if (!mapped)
                    res.status = STAT_NOCART;
                else if (sram_window(it.bank, it.address, idx))
                    sram_image[idx] = it.write_data;
                else
                    res.status = STAT_UNMAPPED;
            end
            OP_LOAD: begin
                off = {it.bank, it.address};
                if (off < ROM_DEPTH) begin
                    if (!rom_image.exists(off))
                        loaded_offsets.push_back(off);
                    rom_image[off] = it.write_data;
                end else begin
                    res.status = STAT_UNMAPPED;
                end
            end
            default: res.status = STAT_UNMAPPED;
        endcase
        return res;
    endfunction

    function automatic t_bus_item bus_item(logic [1:0] op, logic [7:0] bank,
                                           logic [15:0] adr, logic [7:0] wdata,
                                           logic [7:0] obus);
        return '{op: op, bank: bank, address: adr, write_data: wdata,
                 open_bus_value: obus};
    endfunction

    // ---------------------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------------------

    // one input transfer; valid stays high afterwards so back-to-back items flow,
    // and is dropped only when a gap is chosen
    task automatic push_transfer(t_bus_item it);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < in_gap_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= it.op;
        i_bank           <= it.bank;
        i_address        <= it.address;
        i_write_data     <= it.write_data;
        i_open_bus_value <= it.open_bus_value;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        pending_results.push_back(predict_access(it));
    endtask

    // a read that would land on a rom byte never loaded gets that byte loaded first,
    // since unwritten rom has no defined contents
    task automatic send_item(t_bus_item it);
        int unsigned idx;
        if (it.op == OP_READ && (cfg_mode == MODE_LOW || cfg_mode == MODE_HIGH)
                && !sram_window(it.bank, it.address, idx)
                && rom_window(it.bank, it.address, idx) && !rom_image.exists(idx))
            push_transfer(bus_item(OP_LOAD, 8'(idx >> 16), 16'(idx), 8'($urandom),
                                   8'($urandom)));
        push_transfer(it);
    endtask

    // wait until every owed result is back, plus a margin for the pipeline
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // setup then access phase; the register takes the value at the access edge
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAP_MODE:    cfg_mode     = value[1:0];
            REG_ROM_LOG2:    cfg_rom_log2 = value[4:0];
            REG_RAM_LOG2:    cfg_ram_log2 = value[4:0];
            REG_RAM_PRESENT: cfg_ram_on   = value[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [1:0] mode, logic [4:0] rom_log2,
                                 logic [4:0] ram_log2, logic present);
        drain();
        write_reg(REG_MAP_MODE, {30'd0, mode});
        write_reg(REG_ROM_LOG2, {27'd0, rom_log2});
        write_reg(REG_RAM_LOG2, {27'd0, ram_log2});
        write_reg(REG_RAM_PRESENT, {31'd0, present});
    endtask

    // ---------------------------------------------------------------------------------
    // result check and receiver stall
    // ---------------------------------------------------------------------------------

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %02h status %0d", o_read_data,
                       o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data mismatch: expected %02h, actual %02h",
                           want.read_data, o_read_data);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status,
                           o_status);
                    error_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------

    // low map: rom pages at both ends, save ram in both bank ranges, unmapped lower
    // half, write into rom area, load past the rom depth, spare operation code
    task automatic test_low_map();
        apply_setting(MODE_LOW, 5'd19, 5'd13, 1'b1);
        send_item(bus_item(OP_LOAD,  8'h00, 16'h0000, 8'h00, 8'h00));
        send_item(bus_item(OP_LOAD,  8'h07, 16'hffff, 8'hff, 8'hff));
        send_item(bus_item(OP_LOAD,  8'hff, 16'hffff, 8'h3c, 8'h00));
        send_item(bus_item(OP_READ,  8'h00, 16'h8000, 8'h00, 8'h77));
        send_item(bus_item(OP_READ,  8'h8f, 16'hffff, 8'h00, 8'h00));
        send_item(bus_item(OP_WRITE, 8'h70, 16'h0000, 8'ha5, 8'h00));
        send_item(bus_item(OP_READ,  8'h70, 16'h0000, 8'h00, 8'h00));
        send_item(bus_item(OP_WRITE, 8'hff, 16'h7fff, 8'h5a, 8'h00));
        send_item(bus_item(OP_READ,  8'hf0, 16'h7fff, 8'h00, 8'h00));
        send_item(bus_item(OP_WRITE, 8'h00, 16'h8000, 8'h99, 8'h00));
        send_item(bus_item(OP_READ,  8'h00, 16'h0000, 8'h00, 8'hff));
        send_item(bus_item(OP_READ,  8'h7e, 16'h0000, 8'h00, 8'h00));
        send_item(bus_item(OP_SPARE, 8'hff, 16'hffff, 8'hff, 8'hff));
    endtask

    // high map with both size registers past their caps
    task automatic test_high_map();
        apply_setting(MODE_HIGH, 5'd31, 5'd31, 1'b1);
        send_item(bus_item(OP_WRITE, 8'h00, 16'h6000, 8'h11, 8'h00));
        send_item(bus_item(OP_READ,  8'h80, 16'h6000, 8'h00, 8'h00));
        send_item(bus_item(OP_WRITE, 8'hbf, 16'h7fff, 8'h22, 8'h00));
        send_item(bus_item(OP_READ,  8'h00, 16'h5fff, 8'h00, 8'haa));
        send_item(bus_item(OP_READ,  8'hff, 16'hffff, 8'h00, 8'h00));
    endtask

    // ram windows fall through to rom or unmapped decoding when disabled
    task automatic test_ram_disabled();
        apply_setting(MODE_LOW, 5'd19, 5'd13, 1'b0);
        send_item(bus_item(OP_READ,  8'h70, 16'h0000, 8'h00, 8'h00));
        send_item(bus_item(OP_WRITE, 8'h70, 16'h0000, 8'h33, 8'h00));
        apply_setting(MODE_HIGH, 5'd19, 5'd13, 1'b0);
        send_item(bus_item(OP_READ,  8'h00, 16'h6000, 8'h00, 8'h55));
    endtask

    // no mapping, both the named mode and the spare code; loads still land
    task automatic test_no_cartridge();
        apply_setting(MODE_NONE, 5'd19, 5'd11, 1'b1);
        send_item(bus_item(OP_READ,  8'h00, 16'h8000, 8'h00, 8'hc3));
        send_item(bus_item(OP_WRITE, 8'h70, 16'h0000, 8'h44, 8'h00));
        send_item(bus_item(OP_LOAD,  8'h01, 16'h2345, 8'h66, 8'h00));
        apply_setting(MODE_SPARE, 5'd19, 5'd11, 1'b1);
        send_item(bus_item(OP_READ,  8'h70, 16'h0000, 8'h00, 8'h3c));
    endtask

    // zero sizes fold every access onto index zero
    task automatic test_size_extremes();
        apply_setting(MODE_LOW, 5'd0, 5'd0, 1'b1);
        send_item(bus_item(OP_WRITE, 8'hf5, 16'h1234, 8'h7e, 8'h00));
        send_item(bus_item(OP_READ,  8'h70, 16'h0000, 8'h00, 8'h00));
        send_item(bus_item(OP_READ,  8'h12, 16'h8765, 8'h00, 8'h00));
    endtask

    // random traffic, mostly aimed at the windows of the current mapping, with a
    // fresh register setting every so often
    task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct);
        t_bus_item   it;
        int unsigned r;
        int unsigned off;
        logic [4:0]  rom_picks [8];
        logic [4:0]  ram_picks [7];
        logic [1:0]  mode;
        rom_picks = '{5'd0, 5'd1, 5'd15, 5'd16, 5'd18, 5'd19, 5'd22, 5'd31};
        ram_picks = '{5'd0, 5'd1, 5'd11, 5'd12, 5'd13, 5'd19, 5'd31};
        for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % ITEMS_PER_SETTING == 0) begin
                drain();
                in_gap_pct    = gap_pct;
                out_stall_pct = stall_pct;
                r    = $urandom_range(99);
                mode = (r < 40) ? MODE_LOW : (r < 80) ? MODE_HIGH :
                       (r < 90) ? MODE_NONE : MODE_SPARE;
                apply_setting(mode,
                              $urandom_range(3) == 0 ? 5'($urandom) :
                                  rom_picks[$urandom_range(7)],
                              $urandom_range(3) == 0 ? 5'($urandom) :
                                  ram_picks[$urandom_range(6)],
                              $urandom_range(4) != 0);
            end
            it = bus_item(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom));
            r  = $urandom_range(99);
            if (r < 12) begin
                // raw noise, fields as drawn
            end else if (r < 32) begin
                // save ram window of the current mapping
                it.op = $urandom_range(1) ? OP_WRITE : OP_READ;
                if (cfg_mode == MODE_HIGH) begin
                    it.bank[6] = 1'b0;
                    it.address = 16'h6000 | (it.address & 16'h1fff);
                end else begin
                    it.bank = $urandom_range(1) ? 8'(8'h70 + $urandom_range(13))
                                                : (8'hf0 | it.bank[3:0]);
                    it.address[15] = 1'b0;
                end
            end else if (r < 57) begin
                // rom area
                it.op = OP_READ;
                if ($urandom_range(1))
                    it.address[15] = 1'b1;
                else
                    it.bank[6] = 1'b1;
            end else if (r < 67 && loaded_offsets.size() != 0) begin
                // read back a byte loaded earlier
                off   = loaded_offsets[$urandom_range(loaded_offsets.size() - 1)];
                it.op = OP_READ;
                if (cfg_mode == MODE_LOW) begin
                    it.bank    = {it.bank[7], 3'b000, off[18:15]};
                    it.address = {1'b1, off[14:0]};
                end else begin
                    it.bank    = {it.bank[7], 4'b1000, off[18:16]};
                    it.address = off[15:0];
                end
            end else if (r < 82) begin
                // load, now and then past the rom depth
                it.op = OP_LOAD;
                if ($urandom_range(9) != 0)
                    it.bank = 8'($urandom_range((ROM_DEPTH >> 16) - 1));
            end else if (r < 92) begin
                // lower half of the low banks at the window edges
                it.op      = $urandom_range(1) ? OP_WRITE : OP_READ;
                it.bank[6] = 1'b0;
                case ($urandom_range(5))
                    0: it.address = 16'h0000;
                    1: it.address = 16'h5fff;
                    2: it.address = 16'h6000;
                    3: it.address = 16'h7fff;
                    4: it.address = 16'h8000;
                    default: it.address = 16'hffff;
                endcase
            end else if (r < 97) begin
                // write aimed at rom, always refused
                it.op          = OP_WRITE;
                it.address[15] = 1'b1;
            end else begin
                it.op = OP_SPARE;
            end
            send_item(it);
        end
    endtask

    initial begin
        foreach (sram_image[k])
            sram_image[k] = 8'h00;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_operation      <= OP_READ;
        i_bank           <= '0;
        i_address        <= '0;
        i_write_data     <= '0;
        i_open_bus_value <= '0;
        i_out_stall      <= 1'b0;
        in_gap_pct    = 7;
        out_stall_pct = 49;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part; items wait out the save ram clearing pass on the first stall
        test_low_map();
        test_high_map();
        test_ram_disabled();
        test_no_cartridge();
        test_size_extremes();

        // random part under the three idling profiles
        test_random_traffic(7, 49);
        test_random_traffic(49, 7);
        test_random_traffic(0, 0);

        drain();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
